@@ hdl/hcb_pkg.sv @@
// ----------------------------------------------------------------------------
// hcb_pkg: shared constants and types of the huffman code builder
// opcodes, status codes and default sizes used by the rtl and its checker
// ----------------------------------------------------------------------------
package hcb_pkg;

  // default sizes
  localparam int HCB_ALPHABET_SIZE = 256;
  localparam int HCB_WEIGHT_BITS   = 32;
  localparam int HCB_MAX_CODE_BITS = 63;

  // fixed field widths
  localparam int NODE_W = 40;
  localparam int CODE_W = 64;
  localparam int LEN_W  = 6;

  // item opcodes
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2,
    OP_NOP   = 2'd3
  } hcb_op_e;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

endpackage

@@ hdl/hcb_ram.sv @@
// ----------------------------------------------------------------------------
// hcb_ram: generic simple dual port ram
// one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module hcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/huffman_code_builder.sv @@
// ----------------------------------------------------------------------------
// huffman_code_builder: huffman code construction over a small alphabet
// loads symbol counts, builds a prefix code, answers code queries
// ----------------------------------------------------------------------------
// A build walks the symbols once and inserts every present symbol as a leaf
// into a weight sorted queue held in a single ram, then merges the two
// lightest nodes and inserts each merged node until one is left: each
// insertion shifts the lighter entries up one slot at a time. A tree walk
// then visits every node from the root down. The block takes no item while it works.
module huffman_code_builder import hcb_pkg::*; #(
  parameter int ALPHABET_SIZE = HCB_ALPHABET_SIZE,
  parameter int WEIGHT_BITS   = HCB_WEIGHT_BITS,
  parameter int MAX_CODE_BITS = HCB_MAX_CODE_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        opcode_i,
  input  logic [7:0]        symbol_i,
  input  logic [31:0]       weight_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [8:0]        leaf_total_o,
  output logic [CODE_W-1:0] code_bits_o,
  output logic [LEN_W-1:0]  code_length_o
);

  localparam int SYM_W      = $clog2(ALPHABET_SIZE);
  localparam int CNT_W      = $clog2(ALPHABET_SIZE + 1);
  localparam int NODE_DEPTH = 2 * ALPHABET_SIZE - 1;
  localparam int NI_W       = $clog2(NODE_DEPTH);
  localparam int QE_W       = NODE_W + NI_W;
  localparam int NE_W       = 2 * NI_W + SYM_W;
  localparam int CE_W       = CODE_W + LEN_W;
  localparam logic [CODE_W-1:0] CMASK  = (CODE_W'(1) << MAX_CODE_BITS) - CODE_W'(1);
  localparam logic [LEN_W-1:0]  MAXLEN = LEN_W'(MAX_CODE_BITS);
  localparam logic [8:0]        ASIZE  = 9'(ALPHABET_SIZE);
  localparam logic [CNT_W-1:0]  SCAN_END = CNT_W'(ALPHABET_SIZE);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_QRD   = 15'b000000000000010,
    S_SCAN  = 15'b000000000000100,
    S_LEAF  = 15'b000000000001000,
    S_INS   = 15'b000000000010000,
    S_INSC  = 15'b000000000100000,
    S_MCHK  = 15'b000000001000000,
    S_POPA  = 15'b000000010000000,
    S_POPB  = 15'b000000100000000,
    S_WINIT = 15'b000001000000000,
    S_WRD   = 15'b000010000000000,
    S_WDAT  = 15'b000100000000000,
    S_WR2   = 15'b001000000000000,
    S_WNEXT = 15'b010000000000000,
    S_RESP  = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;

  // control registers
  logic [ALPHABET_SIZE-1:0] present_q, present_d;
  logic                     built_q, built_d;
  logic [8:0]               leaf_count_q, leaf_count_d;
  logic [CNT_W-1:0]         scan_q, scan_d;
  logic [CNT_W-1:0]         fill_q, fill_d;
  logic [CNT_W-1:0]         j_q, j_d;
  logic [NI_W-1:0]          leaves_q, leaves_d;
  logic [NI_W-1:0]          next_q, next_d;
  logic [NI_W-1:0]          i_q, i_d;
  logic                     merge_q, merge_d;
  logic                     out_valid_q, out_valid_d;

  // payload registers
  logic [NODE_W-1:0] ins_w_q, ins_w_d;
  logic [NI_W-1:0]   ins_n_q, ins_n_d;
  logic [NODE_W-1:0] a_w_q, a_w_d;
  logic [NI_W-1:0]   a_n_q, a_n_d;
  logic [CODE_W-1:0] base_q, base_d;
  logic [LEN_W-1:0]  nl_q, nl_d;
  logic [NI_W-1:0]   rn_q, rn_d;
  logic [1:0]        resp_st_q, resp_st_d;
  logic [CODE_W-1:0] resp_code_q, resp_code_d;
  logic [LEN_W-1:0]  resp_len_q, resp_len_d;
  logic [1:0]        status_q, status_d;
  logic [8:0]        total_q, total_d;
  logic [CODE_W-1:0] code_q, code_d;
  logic [LEN_W-1:0]  len_q, len_d;

  // ram ports
  logic             w_we;
  logic [SYM_W-1:0] w_waddr, w_raddr;
  logic [WEIGHT_BITS-1:0] w_wdata, w_rdata;
  logic             q_we;
  logic [SYM_W-1:0] q_waddr, q_raddr;
  logic [QE_W-1:0]  q_wdata, q_rdata;
  logic             n_we;
  logic [NI_W-1:0]  n_waddr, n_raddr;
  logic [NE_W-1:0]  n_wdata, n_rdata;
  logic             k_we;
  logic [NI_W-1:0]  k_waddr, k_raddr;
  logic [CE_W-1:0]  k_wdata, k_rdata;
  logic             c_we;
  logic [SYM_W-1:0] c_waddr, c_raddr;
  logic [CE_W-1:0]  c_wdata, c_rdata;

  // decoded read data
  logic [NODE_W-1:0] q_rw;
  logic [NI_W-1:0]   q_rn;
  logic [NI_W-1:0]   n_rl, n_rr;
  logic [SYM_W-1:0]  n_rs;
  logic [CODE_W-1:0] k_rcode;
  logic [LEN_W-1:0]  k_rlen;

  logic             accept;
  logic             sym_ok;
  logic [SYM_W-1:0] sym_idx;

  assign q_rw    = q_rdata[QE_W-1:NI_W];
  assign q_rn    = q_rdata[NI_W-1:0];
  assign n_rl    = n_rdata[NE_W-1:NI_W+SYM_W];
  assign n_rr    = n_rdata[NI_W+SYM_W-1:SYM_W];
  assign n_rs    = n_rdata[SYM_W-1:0];
  assign k_rcode = k_rdata[CE_W-1:LEN_W];
  assign k_rlen  = k_rdata[LEN_W-1:0];

  assign in_ready_o    = (state_q == S_IDLE);
  assign accept        = in_valid_i & in_ready_o;
  assign sym_ok        = ({1'b0, symbol_i} < ASIZE);
  assign sym_idx       = symbol_i[SYM_W-1:0];
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign leaf_total_o  = total_q;
  assign code_bits_o   = code_q;
  assign code_length_o = len_q;

  // symbol weights
  hcb_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(ALPHABET_SIZE)) u_weight_ram (
    .clk_i, .we_i(w_we), .waddr_i(w_waddr), .wdata_i(w_wdata),
    .raddr_i(w_raddr), .rdata_o(w_rdata)
  );

  // weight sorted queue, heaviest at slot 0
  hcb_ram #(.WIDTH(QE_W), .DEPTH(ALPHABET_SIZE)) u_queue_ram (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .raddr_i(q_raddr), .rdata_o(q_rdata)
  );

  // tree nodes: left, right, leaf symbol
  hcb_ram #(.WIDTH(NE_W), .DEPTH(NODE_DEPTH)) u_node_ram (
    .clk_i, .we_i(n_we), .waddr_i(n_waddr), .wdata_i(n_wdata),
    .raddr_i(n_raddr), .rdata_o(n_rdata)
  );

  // per node code during the tree walk
  hcb_ram #(.WIDTH(CE_W), .DEPTH(NODE_DEPTH)) u_walk_ram (
    .clk_i, .we_i(k_we), .waddr_i(k_waddr), .wdata_i(k_wdata),
    .raddr_i(k_raddr), .rdata_o(k_rdata)
  );

  // final code per symbol
  hcb_ram #(.WIDTH(CE_W), .DEPTH(ALPHABET_SIZE)) u_code_ram (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(c_wdata),
    .raddr_i(c_raddr), .rdata_o(c_rdata)
  );

  // sequencer
  always_comb begin
    state_d      = state_q;
    present_d    = present_q;
    built_d      = built_q;
    leaf_count_d = leaf_count_q;
    scan_d       = scan_q;
    fill_d       = fill_q;
    j_d          = j_q;
    leaves_d     = leaves_q;
    next_d       = next_q;
    i_d          = i_q;
    merge_d      = merge_q;
    out_valid_d  = out_valid_q;
    ins_w_d      = ins_w_q;
    ins_n_d      = ins_n_q;
    a_w_d        = a_w_q;
    a_n_d        = a_n_q;
    base_d       = base_q;
    nl_d         = nl_q;
    rn_d         = rn_q;
    resp_st_d    = resp_st_q;
    resp_code_d  = resp_code_q;
    resp_len_d   = resp_len_q;
    status_d     = status_q;
    total_d      = total_q;
    code_d       = code_q;
    len_d        = len_q;

    w_we    = 1'b0;
    w_waddr = sym_idx;
    w_wdata = weight_i[WEIGHT_BITS-1:0];
    w_raddr = scan_q[SYM_W-1:0];
    q_we    = 1'b0;
    q_waddr = j_q[SYM_W-1:0];
    q_wdata = {ins_w_q, ins_n_q};
    q_raddr = SYM_W'(j_q - CNT_W'(1));
    n_we    = 1'b0;
    n_waddr = leaves_q;
    n_wdata = {{(2*NI_W){1'b0}}, scan_q[SYM_W-1:0]};
    n_raddr = i_q;
    k_we    = 1'b0;
    k_waddr = n_rl;
    k_wdata = {base_q, nl_q};
    k_raddr = i_q;
    c_we    = 1'b0;
    c_waddr = n_rs;
    c_wdata = k_rdata;
    c_raddr = sym_idx;

    // result slot drains independently
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          resp_code_d = '0;
          resp_len_d  = '0;
          unique case (opcode_i)
            OP_LOAD: begin
              if (sym_ok) begin
                w_we = 1'b1;
                if (built_q) begin
                  present_d    = '0;
                  built_d      = 1'b0;
                  leaf_count_d = 9'd1;
                end else if (!present_q[sym_idx]) begin
                  leaf_count_d = leaf_count_q + 9'd1;
                end
                present_d[sym_idx] = 1'b1;
              end
            end
            OP_BUILD: begin
              built_d = 1'b1;
              if (leaf_count_q == 9'd0) begin
                resp_st_d = ST_EMPTY;
                state_d   = S_RESP;
              end else begin
                resp_st_d = ST_OK;
                scan_d    = '0;
                leaves_d  = '0;
                fill_d    = '0;
                merge_d   = 1'b0;
                state_d   = S_SCAN;
              end
            end
            OP_QUERY: begin
              if (built_q && sym_ok && present_q[sym_idx]) begin
                resp_st_d = ST_OK;
                state_d   = S_QRD;
              end else begin
                resp_st_d = ST_ABSENT;
                state_d   = S_RESP;
              end
            end
            OP_NOP: begin
            end
            default: begin
            end
          endcase
        end
      end

      // code ram data is ready
      S_QRD: begin
        resp_code_d = c_rdata[CE_W-1:LEN_W];
        resp_len_d  = c_rdata[LEN_W-1:0];
        state_d     = S_RESP;
      end

      // walk symbols in ascending order
      S_SCAN: begin
        if (scan_q == SCAN_END) begin
          next_d  = leaves_q;
          merge_d = 1'b1;
          state_d = S_MCHK;
        end else if (present_q[scan_q[SYM_W-1:0]]) begin
          state_d = S_LEAF;
        end else begin
          scan_d = scan_q + CNT_W'(1);
        end
      end

      // create leaf node and insert it
      S_LEAF: begin
        n_we     = 1'b1;
        ins_w_d  = NODE_W'(w_rdata);
        ins_n_d  = leaves_q;
        leaves_d = leaves_q + NI_W'(1);
        scan_d   = scan_q + CNT_W'(1);
        j_d      = fill_q;
        state_d  = S_INS;
      end

      // insertion: read the entry below the hole
      S_INS: begin
        if (j_q == '0) begin
          q_we   = 1'b1;
          fill_d = fill_q + CNT_W'(1);
          state_d = merge_q ? S_MCHK : S_SCAN;
        end else begin
          state_d = S_INSC;
        end
      end

      // lighter entries move up, else the new node lands here
      S_INSC: begin
        q_we = 1'b1;
        if (q_rw < ins_w_q) begin
          q_wdata = q_rdata;
          j_d     = j_q - CNT_W'(1);
          state_d = S_INS;
        end else begin
          fill_d  = fill_q + CNT_W'(1);
          state_d = merge_q ? S_MCHK : S_SCAN;
        end
      end

      // pop the lightest two while more than one node is queued
      S_MCHK: begin
        q_raddr = SYM_W'(fill_q - CNT_W'(1));
        if (fill_q > CNT_W'(1)) begin
          fill_d  = fill_q - CNT_W'(1);
          state_d = S_POPA;
        end else begin
          state_d = S_WINIT;
        end
      end

      S_POPA: begin
        q_raddr = SYM_W'(fill_q - CNT_W'(1));
        a_w_d   = q_rw;
        a_n_d   = q_rn;
        fill_d  = fill_q - CNT_W'(1);
        state_d = S_POPB;
      end

      // merged node, first pop to the left
      S_POPB: begin
        n_we    = 1'b1;
        n_waddr = next_q;
        n_wdata = {a_n_q, q_rn, {SYM_W{1'b0}}};
        ins_w_d = a_w_q + q_rw;
        ins_n_d = next_q;
        next_d  = next_q + NI_W'(1);
        j_d     = fill_q;
        state_d = S_INS;
      end

      // root gets the empty code
      S_WINIT: begin
        k_we    = 1'b1;
        k_waddr = next_q - NI_W'(1);
        k_wdata = '0;
        i_d     = next_q - NI_W'(1);
        state_d = S_WRD;
      end

      S_WRD: begin
        state_d = S_WDAT;
      end

      // internal node passes its code down, leaf stores it
      S_WDAT: begin
        if (i_q >= leaves_q) begin
          base_d  = (k_rcode << 1) & CMASK;
          nl_d    = (k_rlen < MAXLEN) ? k_rlen + LEN_W'(1) : MAXLEN;
          rn_d    = n_rr;
          k_we    = 1'b1;
          k_waddr = n_rl;
          k_wdata = {(k_rcode << 1) & CMASK,
                     (k_rlen < MAXLEN) ? k_rlen + LEN_W'(1) : MAXLEN};
          state_d = S_WR2;
        end else begin
          c_we    = 1'b1;
          state_d = S_WNEXT;
        end
      end

      S_WR2: begin
        k_we    = 1'b1;
        k_waddr = rn_q;
        k_wdata = {base_q | CODE_W'(1), nl_q};
        state_d = S_WNEXT;
      end

      S_WNEXT: begin
        if (i_q == '0) begin
          state_d = S_RESP;
        end else begin
          i_d     = i_q - NI_W'(1);
          state_d = S_WRD;
        end
      end

      // hand the result to the output register
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = resp_st_q;
          total_d     = leaf_count_q;
          code_d      = resp_code_q;
          len_d       = resp_len_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      present_q    <= '0;
      built_q      <= 1'b0;
      leaf_count_q <= '0;
      scan_q       <= '0;
      fill_q       <= '0;
      j_q          <= '0;
      leaves_q     <= '0;
      next_q       <= '0;
      i_q          <= '0;
      merge_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      present_q    <= present_d;
      built_q      <= built_d;
      leaf_count_q <= leaf_count_d;
      scan_q       <= scan_d;
      fill_q       <= fill_d;
      j_q          <= j_d;
      leaves_q     <= leaves_d;
      next_q       <= next_d;
      i_q          <= i_d;
      merge_q      <= merge_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    ins_w_q     <= ins_w_d;
    ins_n_q     <= ins_n_d;
    a_w_q       <= a_w_d;
    a_n_q       <= a_n_d;
    base_q      <= base_d;
    nl_q        <= nl_d;
    rn_q        <= rn_d;
    resp_st_q   <= resp_st_d;
    resp_code_q <= resp_code_d;
    resp_len_q  <= resp_len_d;
    status_q    <= status_d;
    total_q     <= total_d;
    code_q      <= code_d;
    len_q       <= len_d;
  end

endmodule

@@ hdl/hcb_checker.sv @@
// ----------------------------------------------------------------------------
// hcb_checker: port level checks of the huffman code builder
// bound to the top level, watches the handshakes and result fields
// ----------------------------------------------------------------------------
module hcb_checker import hcb_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic [1:0]        opcode_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [1:0]        status_o,
  input logic [8:0]        leaf_total_o,
  input logic [CODE_W-1:0] code_bits_o,
  input logic [LEN_W-1:0]  code_length_o
);

  // a waiting result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(code_bits_o))
    else $error("result dropped or changed while stalled");

  // build and query items block the input while they work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (opcode_i == OP_BUILD || opcode_i == OP_QUERY) |=> !in_ready_o)
    else $error("input taken during a build or query");

  // an empty set reports no leaves and no code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> leaf_total_o == 9'd0 && code_length_o == '0)
    else $error("empty build result carries data");

  // a failed query carries no code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_ABSENT |-> code_bits_o == '0 && code_length_o == '0)
    else $error("absent symbol result carries a code");

endmodule

bind huffman_code_builder hcb_checker u_hcb_checker (.*);
